FILE: rtl/core/sdp_pkg.sv
// Package for the sparse dot product block: stream widths, function codes
// and the merge controller state type.
// No dependencies.
package sdp_pkg;

  localparam int MAX_ENTRIES_DEF = 256;

  localparam int COL_W      = 16;
  localparam int VAL_W      = 32;
  localparam int ACC_W      = 64;
  localparam int IN_DATA_W  = COL_W + VAL_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = ACC_W;
  localparam int OUT_USER_W = 2;

  localparam logic [IN_USER_W-1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [IN_USER_W-1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [IN_USER_W-1:0] FUNC_END    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

FILE: rtl/core/sparse_dot_product.sv
// Sparse dot product: two entry memories merged by column on an end transfer.
// Depends on sdp_pkg. Transfers are taken only while idle. An end runs merge
// steps (at most first_count + second_count - 1), each a read state and a
// compare state, then a drain state and a result state that waits for
// out_tready to take the previous result; an empty vector goes there at once.
// Synchronous rst_n clears counts, flags and control; memories are not cleared.
module sparse_dot_product #(
  parameter int MAX_ENTRIES = sdp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // column [15:0], value [47:16]
  input  logic [sdp_pkg::IN_DATA_W-1:0]    in_tdata,
  // func [1:0]
  input  logic [sdp_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // dot_product [63:0]
  output logic [sdp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // saturated [0], dropped_entries [1]
  output logic [sdp_pkg::OUT_USER_W-1:0]   out_tuser
);
  import sdp_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

  localparam logic signed [ACC_W-1:0] ACC_POS = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_NEG = {1'b1, {(ACC_W-1){1'b0}}};

  logic [IN_DATA_W-1:0] mem_a [MAX_ENTRIES];
  logic [IN_DATA_W-1:0] mem_b [MAX_ENTRIES];
  logic [IN_DATA_W-1:0] rd_a_r, rd_b_r;

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          drop_r, drop_nxt;
  logic          sat_r, sat_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic          prod_v_r, prod_v_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic          in_xfer, we_a, we_b, out_load;
  logic [COL_W-1:0] col_a, col_b;
  logic signed [VAL_W-1:0] val_a, val_b;
  logic signed [ACC_W:0]   sum_ext;

  assign in_xfer = in_tvalid && in_tready;
  assign we_a = in_xfer && (in_tuser == FUNC_LOAD_A) && (cnt_a_r < CNT_MAX);
  assign we_b = in_xfer && (in_tuser == FUNC_LOAD_B) && (cnt_b_r < CNT_MAX);

  assign col_a = rd_a_r[COL_W-1:0];
  assign col_b = rd_b_r[COL_W-1:0];
  assign val_a = $signed(rd_a_r[IN_DATA_W-1:COL_W]);
  assign val_b = $signed(rd_b_r[IN_DATA_W-1:COL_W]);

  assign sum_ext = {acc_r[ACC_W-1], acc_r} + {prod_r[ACC_W-1], prod_r};

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[cnt_a_r[AW-1:0]] <= in_tdata;
    end
    if (we_b) begin
      mem_b[cnt_b_r[AW-1:0]] <= in_tdata;
    end
    if (state_r == ST_RD) begin
      rd_a_r <= mem_a[i_r[AW-1:0]];
      rd_b_r <= mem_b[j_r[AW-1:0]];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_a_nxt  = cnt_a_r;
    cnt_b_nxt  = cnt_b_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    drop_nxt   = drop_r;
    sat_nxt    = sat_r;
    acc_nxt    = acc_r;
    prod_nxt   = val_a * val_b;
    prod_v_nxt = 1'b0;
    in_tready  = 1'b0;
    out_load   = 1'b0;

    if (prod_v_r) begin
      if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
        acc_nxt = prod_r[ACC_W-1] ? ACC_NEG : ACC_POS;
        sat_nxt = 1'b1;
      end else begin
        acc_nxt = sum_ext[ACC_W-1:0];
      end
    end

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_tuser)
            FUNC_LOAD_A: begin
              if (cnt_a_r < CNT_MAX) cnt_a_nxt = cnt_a_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            FUNC_LOAD_B: begin
              if (cnt_b_r < CNT_MAX) cnt_b_nxt = cnt_b_r + 1'b1;
              else drop_nxt = 1'b1;
            end
            FUNC_END: begin
              i_nxt   = '0;
              j_nxt   = '0;
              acc_nxt = '0;
              sat_nxt = 1'b0;
              if ((cnt_a_r == '0) || (cnt_b_r == '0)) state_nxt = ST_FIN;
              else state_nxt = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (col_a < col_b) begin
          i_nxt = i_r + 1'b1;
        end else if (col_b < col_a) begin
          j_nxt = j_r + 1'b1;
        end else begin
          i_nxt      = i_r + 1'b1;
          j_nxt      = j_r + 1'b1;
          prod_v_nxt = 1'b1;
        end
        if ((i_nxt < cnt_a_r) && (j_nxt < cnt_b_r)) state_nxt = ST_RD;
        else state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          cnt_a_nxt = '0;
          cnt_b_nxt = '0;
          drop_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      drop_r      <= 1'b0;
      sat_r       <= 1'b0;
      prod_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      drop_r      <= drop_nxt;
      sat_r       <= sat_nxt;
      prod_v_r    <= prod_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (out_load) begin
      out_data_r <= acc_r;
      out_user_r <= {drop_r, sat_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_MAX) && (cnt_b_r <= CNT_MAX))
    else $error("entry count beyond depth");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> ((i_r < cnt_a_r) && (j_r < cnt_b_r)))
    else $error("merge read past loaded entries");

  a_prod_drained: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r |-> ((state_r == ST_RD) || (state_r == ST_DRAIN)))
    else $error("product pending outside merge");

  a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> ((cnt_a_r == '0) && (cnt_b_r == '0) && !drop_r && out_valid_r))
    else $error("buffers not emptied after result");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for sparse_dot_product: loads pairs of sparse vectors
// over the input stream and checks each dot product against a built-in merge
// predictor. Depends on sdp_pkg and the sparse_dot_product RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdp_pkg::*;

  localparam int DEPTH = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int HOLD_OFF_CYCLES = 2000;
  localparam logic [IN_USER_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct {
    logic signed [ACC_W-1:0] dot;
    logic                    sat;
    logic                    drop;
  } dot_result_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } sparse_entry_t;

  class dot_product_scoreboard;
    logic [COL_W-1:0]        cols_a[DEPTH];
    logic signed [VAL_W-1:0] vals_a[DEPTH];
    logic [COL_W-1:0]        cols_b[DEPTH];
    logic signed [VAL_W-1:0] vals_b[DEPTH];
    int                      count_a;
    int                      count_b;
    logic                    overflow;
    dot_result_t             expected_sums[$];
    int                      errors;

    function new();
      count_a = 0;
      count_b = 0;
      overflow = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    function void take_entry(logic [IN_USER_W-1:0] func, logic [COL_W-1:0] col,
                             logic [VAL_W-1:0] val);
      int i;
      int j;
      logic signed [ACC_W-1:0] acc;
      logic signed [ACC_W-1:0] prod;
      logic signed [ACC_W-1:0] sum;
      logic clipped;
      dot_result_t res;
      case (func)
        FUNC_LOAD_A: begin
          if (count_a >= DEPTH) begin
            overflow = 1'b1;
          end else begin
            cols_a[count_a] = col;
            vals_a[count_a] = val;
            count_a++;
          end
        end
        FUNC_LOAD_B: begin
          if (count_b >= DEPTH) begin
            overflow = 1'b1;
          end else begin
            cols_b[count_b] = col;
            vals_b[count_b] = val;
            count_b++;
          end
        end
        FUNC_END: begin
          i = 0;
          j = 0;
          acc = '0;
          clipped = 1'b0;
          while (i < count_a && j < count_b) begin
            if (cols_a[i] < cols_b[j]) begin
              i++;
            end else if (cols_b[j] < cols_a[i]) begin
              j++;
            end else begin
              prod = vals_a[i] * vals_b[j];
              sum = acc + prod;
              if (acc[ACC_W-1] == prod[ACC_W-1] && sum[ACC_W-1] != acc[ACC_W-1]) begin
                clipped = 1'b1;
                sum = prod[ACC_W-1] ? ACC_MIN : ACC_MAX;
              end
              acc = sum;
              i++;
              j++;
            end
          end
          res.dot = acc;
          res.sat = clipped;
          res.drop = overflow;
          expected_sums.push_back(res);
          count_a = 0;
          count_b = 0;
          overflow = 1'b0;
        end
        default: begin
        end
      endcase
    endfunction

    task report(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_sum(logic [OUT_DATA_W-1:0] data, logic [OUT_USER_W-1:0] user);
      dot_result_t want;
      if (expected_sums.size() == 0) begin
        report("unexpected result", data, '0);
      end else begin
        want = expected_sums.pop_front();
        if (data !== want.dot) report("dot_product", data, want.dot);
        if (user[0] !== want.sat) begin
          report("saturated", ACC_W'(user[0]), ACC_W'(want.sat));
        end
        if (user[1] !== want.drop) begin
          report("dropped_entries", ACC_W'(user[1]), ACC_W'(want.drop));
        end
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  dot_product_scoreboard sb;
  int  in_idle_pct = 35;
  int  out_idle_pct = 45;
  int  items_sent = 0;
  int  cycles = 0;
  bit  hold_req = 1'b0;

  sparse_dot_product #(.MAX_ENTRIES(DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  // Sink side: check each transfer, then pick the next tready.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_sum(out_tdata, out_tuser);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task send_item(logic [IN_USER_W-1:0] func, logic [COL_W-1:0] col,
                 logic [VAL_W-1:0] val);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {val, col};
    do @(posedge clk); while (!in_tready);
    sb.take_entry(func, col, val);
    items_sent++;
  endtask

  function logic [VAL_W-1:0] pick_value(int vmode);
    logic [VAL_W-1:0] v;
    case (vmode)
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h3ffff) - 32'h20000;
      2: begin
        case ($urandom_range(4))
          0: v = 32'h7fffffff;
          1: v = 32'h80000000;
          2: v = 32'hffffffff;
          3: v = 32'h00000001;
          default: v = '0;
        endcase
      end
      default: v = 32'h80000000;
    endcase
    return v;
  endfunction

  task run_vector(int n_a, int n_b, int match_pct, int vmode, bit sorted);
    sparse_entry_t qa[$];
    sparse_entry_t qb[$];
    sparse_entry_t e;
    int col;
    col = $urandom_range(0, 65535 - 4 * (n_a + n_b) - 4);
    while (qa.size() < n_a || qb.size() < n_b) begin
      if (sorted) col += $urandom_range(1, 3);
      else col = $urandom_range(0, 15);
      if (qa.size() < n_a && qb.size() < n_b && $urandom_range(99) < match_pct) begin
        qa.push_back('{col[COL_W-1:0], pick_value(vmode)});
        qb.push_back('{col[COL_W-1:0], pick_value(vmode)});
      end else if (qa.size() < n_a && (qb.size() >= n_b || $urandom_range(1))) begin
        qa.push_back('{col[COL_W-1:0], pick_value(vmode)});
      end else begin
        qb.push_back('{col[COL_W-1:0], pick_value(vmode)});
      end
    end
    while (qa.size() > 0 || qb.size() > 0) begin
      if ($urandom_range(99) < 4) send_item(FUNC_UNUSED, COL_W'($urandom), $urandom);
      if (qa.size() > 0 && (qb.size() == 0 || $urandom_range(1))) begin
        e = qa.pop_front();
        send_item(FUNC_LOAD_A, e.col, e.val);
      end else begin
        e = qb.pop_front();
        send_item(FUNC_LOAD_B, e.col, e.val);
      end
    end
    send_item(FUNC_END, COL_W'($urandom), $urandom);
  endtask

  // Fill one buffer past its depth; the other gets a few matching columns.
  task run_overflow(bit into_second);
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_item(into_second ? FUNC_LOAD_B : FUNC_LOAD_A, 16'(3 * i + 1), $urandom);
    end
    for (int k = 0; k < 20; k++) begin
      send_item(into_second ? FUNC_LOAD_A : FUNC_LOAD_B, 16'(39 * k + 1), $urandom);
    end
    send_item(FUNC_END, COL_W'($urandom), $urandom);
  endtask

  task random_vector();
    int r;
    int big;
    r = $urandom_range(99);
    big = ($urandom_range(9) == 0) ? 40 : 8;
    if (r < 70) begin
      run_vector($urandom_range(0, big), $urandom_range(0, big), 50,
                 $urandom_range(0, 2), 1'b1);
    end else if (r < 80) begin
      run_vector($urandom_range(1, 8), $urandom_range(1, 8), 30,
                 $urandom_range(0, 2), 1'b0);
    end else if (r < 88) begin
      repeat ($urandom_range(1, 4)) begin
        send_item(IN_USER_W'($urandom_range(0, 3)), COL_W'($urandom), $urandom);
      end
    end else if (r < 93) begin
      run_vector($urandom_range(2, 6), $urandom_range(2, 6), 90, 3, 1'b1);
    end else if ($urandom_range(1)) begin
      run_vector($urandom_range(1, 6), 0, 0, 0, 1'b1);
    end else begin
      run_vector(0, $urandom_range(1, 6), 0, 0, 1'b1);
    end
  endtask

  initial begin
    sb = new;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(FUNC_LOAD_A, 16'd0, 32'h7fffffff);
    send_item(FUNC_LOAD_B, 16'd0, 32'h7fffffff);
    send_item(FUNC_LOAD_A, 16'hffff, 32'h80000000);
    send_item(FUNC_LOAD_B, 16'hffff, 32'h80000000);
    send_item(FUNC_END, 16'hffff, 32'hffffffff);
    for (int i = 1; i <= 3; i++) begin
      send_item(FUNC_LOAD_A, 16'(i), 32'h80000000);
      send_item(FUNC_LOAD_B, 16'(i), 32'h80000000);
    end
    send_item(FUNC_END, '0, '0);
    for (int i = 10; i <= 12; i++) begin
      send_item(FUNC_LOAD_A, 16'(i), 32'h80000000);
      send_item(FUNC_LOAD_B, 16'(i), 32'h7fffffff);
    end
    send_item(FUNC_END, '0, '0);
    send_item(FUNC_LOAD_A, 16'd7, 32'h00010000);
    send_item(FUNC_END, '0, '0);
    send_item(FUNC_UNUSED, 16'hffff, 32'hffffffff);
    send_item(FUNC_END, '0, '0);
    send_item(FUNC_LOAD_A, 16'd5, 32'h00020000);
    send_item(FUNC_LOAD_A, 16'd3, 32'h00030000);
    send_item(FUNC_LOAD_B, 16'd3, 32'h00040000);
    send_item(FUNC_LOAD_B, 16'd5, 32'hfffe0000);
    send_item(FUNC_END, '0, '0);

    hold_req = 1'b1;
    run_overflow(1'b0);
    while (items_sent < 400) random_vector();
    in_idle_pct = 45;
    out_idle_pct = 35;
    while (items_sent < 700) random_vector();
    run_overflow(1'b1);
    in_idle_pct = 0;
    out_idle_pct = 0;
    while (items_sent < 1200) random_vector();
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
